/* src/pncs_pkg.sv */
`timescale 1ns / 1ps

package pncs_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int SCN_W = IDX_W + 1;

	localparam int OP_W = 2;
	localparam int EIDX_W = 16;
	localparam int CH_W = 8;
	localparam int COLOR_W = 3 * CH_W;
	localparam int CNT_W = 9;
	localparam int FOUND_W = 9;
	localparam int SQ_W = 2 * CH_W;
	localparam int DIST_W = SQ_W + 2;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	// query channels drop their two low bits
	localparam logic [CH_W-1:0] QUANT_MASK = 8'hFC;

	typedef struct packed {
		logic clr;
		logic valid;
		logic [IDX_W-1:0] idx;
	} dist_ctl_t;

endpackage

/* src/pncs_chan_if.sv */
`timescale 1ns / 1ps

interface pncs_req_if import pncs_pkg::*; ();
	logic valid;
	logic ready;
	logic [OP_W-1:0] op;
	logic signed [EIDX_W-1:0] entry_index;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, op, entry_index, red, green, blue, input ready);
	modport sink (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface pncs_rsp_if import pncs_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [FOUND_W-1:0] found_index;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;

	modport source (output valid, found_index, out_red, out_green, out_blue, input ready);
	modport sink (input valid, found_index, out_red, out_green, out_blue, output ready);
endinterface

interface pncs_cfg_if import pncs_pkg::*; ();
	logic valid;
	logic ready;
	logic [CNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* src/palette_nearest_color_search.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake      Word
// req      in   valid/ready    op, entry_index, red, green, blue
// rsp      out  valid/ready    found_index, out_red, out_green, out_blue
// cfg      in   valid/ready    data (entry_count, always ready)
//
// One item at a time. A write, an unused op or an empty-palette query or read
// goes straight to the done state, a read through the read state, and a query
// through the scan state, where the palette RAM feeds one entry per cycle into
// the distance/compare unit. req is ready again once the output register loads.
// arst_n clears the sequencer, the entry count and the result valid; the
// palette RAM is not cleared. A stalled rsp holds its word; one more item is
// processed behind it and then waits in the done state with req held low.

module palette_nearest_color_search import pncs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pncs_req_if.sink req,
	pncs_rsp_if.source rsp,
	pncs_cfg_if.sink cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [CNT_W-1:0] entry_count_q;
	logic [SCN_W-1:0] act_cnt;
	logic [SCN_W-1:0] scan_q;
	logic [COLOR_W-1:0] qry_q;
	logic v_s1;
	logic [IDX_W-1:0] idx_s1;

	logic accept;
	logic issue;
	logic out_free;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [COLOR_W-1:0] ram_wdata;
	logic ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [COLOR_W-1:0] ram_rdata;
	logic [IDX_W-1:0] rd_clamp;
	logic idx_pos;
	logic [31:0] idx_abs;

	dist_ctl_t dctl;
	logic [IDX_W-1:0] best_idx;
	logic dist_busy;

	logic signed [FOUND_W-1:0] res_found_q;
	logic [CH_W-1:0] res_red_q, res_green_q, res_blue_q;
	logic rsp_valid_q;
	logic signed [FOUND_W-1:0] out_found_q;
	logic [CH_W-1:0] out_red_q, out_green_q, out_blue_q;

	// Entries in use: the register value, capped at the RAM depth.
	assign act_cnt = (32'(entry_count_q) >= 32'(PALETTE_DEPTH)) ?
			SCN_W'(PALETTE_DEPTH) : SCN_W'(entry_count_q);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg.valid) begin
			entry_count_q <= cfg.data;
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign accept = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// Index decode: writes need 0..DEPTH-1, reads clamp to 0..count-1.
	assign idx_pos = !req.entry_index[EIDX_W-1];
	assign idx_abs = 32'(req.entry_index[EIDX_W-2:0]);
	always_comb begin
		if (!idx_pos) begin
			rd_clamp = '0;
		end else if (idx_abs >= 32'(act_cnt)) begin
			rd_clamp = IDX_W'(act_cnt - SCN_W'(1));
		end else begin
			rd_clamp = IDX_W'(idx_abs);
		end
	end

	assign ram_we = accept && (req.op == OP_WRITE) && idx_pos &&
			(idx_abs < 32'(PALETTE_DEPTH));
	assign ram_waddr = IDX_W'(idx_abs);
	assign ram_wdata = {req.blue, req.green, req.red};

	// Scan issues one address a cycle until all active entries are out.
	assign issue = (state_q == ST_SCAN) && (scan_q < act_cnt);
	assign ram_re = issue || (accept && (req.op == OP_READ));
	assign ram_raddr = issue ? scan_q[IDX_W-1:0] : rd_clamp;

	pncs_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Tag the RAM output with its valid and index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[IDX_W-1:0];
	end

	assign dctl.clr = accept && (req.op == OP_QUERY);
	assign dctl.valid = v_s1;
	assign dctl.idx = idx_s1;

	pncs_dist u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(dctl),
		.ent(ram_rdata),
		.qry(qry_q),
		.best_idx(best_idx),
		.busy(dist_busy)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_q <= '0;
						if (req.op == OP_QUERY && act_cnt != '0) begin
							state_q <= ST_SCAN;
						end else if (req.op == OP_READ && act_cnt != '0) begin
							state_q <= ST_READ;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + SCN_W'(1);
					end else if (!v_s1 && !dist_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result staging: payload only.
	always_ff @(posedge clk) begin
		if (accept) begin
			qry_q <= {req.blue & QUANT_MASK, req.green & QUANT_MASK,
					req.red & QUANT_MASK};
			res_found_q <= '0;
			res_red_q <= '0;
			res_green_q <= '0;
			res_blue_q <= '0;
			if (req.op == OP_QUERY && act_cnt == '0) begin
				res_found_q <= '1;
			end
		end else if (state_q == ST_READ) begin
			res_red_q <= ram_rdata[CH_W-1:0];
			res_green_q <= ram_rdata[2*CH_W-1:CH_W];
			res_blue_q <= ram_rdata[3*CH_W-1:2*CH_W];
		end else if (state_q == ST_SCAN && !issue && !v_s1 && !dist_busy) begin
			res_found_q <= FOUND_W'(best_idx);
		end
	end

	// Output register: load from staging when free, drop valid when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_found_q <= res_found_q;
			out_red_q <= res_red_q;
			out_green_q <= res_green_q;
			out_blue_q <= res_blue_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.found_index = out_found_q;
	assign rsp.out_red = out_red_q;
	assign rsp.out_green = out_green_q;
	assign rsp.out_blue = out_blue_q;

`ifndef NO_ASSERTIONS
	a_ram_tag_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
			v_s1 |-> state_q == ST_SCAN)
		else $error("RAM data tag valid outside of scan");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
			ram_we |-> state_q == ST_IDLE)
		else $error("palette write while busy");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
			state_q == ST_SCAN |-> scan_q <= act_cnt)
		else $error("scan address past active entries");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == ST_DONE && out_free) |=> rsp_valid_q)
		else $error("finished result not loaded into output register");
`endif

endmodule

/* src/pncs_ram.sv */
`timescale 1ns / 1ps

module pncs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/pncs_dist.sv */
`timescale 1ns / 1ps

module pncs_dist import pncs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dist_ctl_t ctl,
	input  logic [COLOR_W-1:0] ent,
	input  logic [COLOR_W-1:0] qry,
	output logic [IDX_W-1:0] best_idx,
	output logic busy
);

	logic [CH_W-1:0] dr, dg, db;
	logic [SQ_W-1:0] sqr_s2, sqg_s2, sqb_s2;
	logic [IDX_W-1:0] idx_s2;
	logic v_s2;
	logic [DIST_W-1:0] sum;
	logic [DIST_W-1:0] best_dist_q;
	logic [IDX_W-1:0] best_idx_q;

	function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	assign dr = absdiff(ent[CH_W-1:0], qry[CH_W-1:0]);
	assign dg = absdiff(ent[2*CH_W-1:CH_W], qry[2*CH_W-1:CH_W]);
	assign db = absdiff(ent[3*CH_W-1:2*CH_W], qry[3*CH_W-1:2*CH_W]);

	// squares of the three channel differences
	always_ff @(posedge clk) begin
		sqr_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sqg_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sqb_s2 <= SQ_W'(db) * SQ_W'(db);
		idx_s2 <= ctl.idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl.valid;
		end
	end

	assign sum = DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);

	// strict less keeps the lowest index on a tie
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			best_dist_q <= '1;
			best_idx_q <= '0;
		end else if (v_s2 && (sum < best_dist_q)) begin
			best_dist_q <= sum;
			best_idx_q <= idx_s2;
		end
	end

	assign best_idx = best_idx_q;
	assign busy = v_s2;

endmodule
